// File: hdl/rls_pkg.sv
package rls_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 32;
  localparam int NS_W    = 37;
  localparam int TICK_W  = 24;
  localparam int RAM_W   = CNT_W + 2 * NS_W;

  localparam logic [TICK_W-1:0] TICK_RESET = 24'd65536;
  localparam logic [71:0]       LIMIT_NS   = 72'd100000000000;
  localparam logic [NS_W-1:0]   NS_MAX     = {NS_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  localparam logic [1:0] STAT_MERGED = 2'd0;
  localparam logic [1:0] STAT_ORDER  = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

endpackage

// File: hdl/rls_ram.sv
module rls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/running_latency_statistics.sv
// Running latency statistics per entry (count, mean and deviation in ns).
// Input channel in_*: one request carries an entry index and a start and an
// end timestamp. Result channel out_*: one result per request with a status,
// the entry index and the entry's count, mean and deviation after the step.
// Configuration channel cfg_*: writes the tick period (Q8.16 ns per tick).
// One request is processed at a time. A request with its end not after its
// start goes from the read state straight to the finish state; a latency over
// the limit or a first sample adds the tick scaling; a merge runs a shift-add
// multiplier over seven products (one multiplier bit a cycle, stopping once
// the remaining bits are zero), a restoring divider for the mean and the
// variance and a two-bit-a-cycle square root, all in one serial datapath.
// Reset clears every entry's count through per-entry valid flags and loads a
// tick period of 1.0 ns; the entry memory (count, mean, deviation) is written on first use.
// A finished result waits in the output register while the receiver stalls;
// a new request is taken once the previous one has reached that register.
module running_latency_statistics
  import rls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [63:0]       in_start_tick,
  input  logic [63:0]       in_end_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_entry_echo,
  output logic [CNT_W-1:0]  out_sample_count,
  output logic [NS_W-1:0]   out_mean_ns,
  output logic [NS_W-1:0]   out_std_ns,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TICK_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [2:0] OP_LAT  = 3'd0;
  localparam logic [2:0] OP_NM   = 3'd1;
  localparam logic [2:0] OP_SS   = 3'd2;
  localparam logic [2:0] OP_TS   = 3'd3;
  localparam logic [2:0] OP_DD   = 3'd4;
  localparam logic [2:0] OP_NU   = 3'd5;
  localparam logic [2:0] OP_BQ   = 3'd6;
  localparam logic [2:0] OP_MEAN = 3'd7;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [1:0]        out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_echo_r, out_echo_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [NS_W-1:0]   out_mean_r, out_mean_nxt;
  logic [NS_W-1:0]   out_std_r, out_std_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [63:0]       diff_r, diff_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [NS_W-1:0]   m0_r, m0_nxt;
  logic [NS_W-1:0]   s0_r, s0_nxt;
  logic [NS_W-1:0]   x_r, x_nxt;
  logic [NS_W-1:0]   d_r, d_nxt;
  logic [NS_W-1:0]   mean_r, mean_nxt;
  logic [NS_W-1:0]   dev_r, dev_nxt;
  logic [140:0]      ma_r, ma_nxt;
  logic [36:0]       mb_r, mb_nxt;
  logic [140:0]      acc_r, acc_nxt;
  logic [140:0]      hold_r, hold_nxt;
  logic [70:0]       mnum_r, mnum_nxt;
  logic [64:0]       den_r, den_nxt;
  logic [65:0]       rem_r, rem_nxt;
  logic [65:0]       dsor_r, dsor_nxt;
  logic [140:0]      dvd_r, dvd_nxt;
  logic [76:0]       q_r, q_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [77:0]       sq_r, sq_nxt;
  logic [38:0]       root_r, root_nxt;
  logic [40:0]       srem_r, srem_nxt;

  // memory
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  // datapath helpers
  logic              in_fire, out_free;
  logic [32:0]       n1;
  logic [NS_W-1:0]   xv, dv;
  logic [CNT_W-1:0]  cnt_new;
  logic [66:0]       dtry;
  logic              dge;
  logic [42:0]       strem, strial;
  logic              sge;
  logic [39:0]       rnd;
  logic [140:0]      u_sum;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign ram_raddr = (state_r == S_IDLE) ? in_entry_index : idx_r;

  assign n1      = {1'b0, n_r} + 33'd1;
  assign xv      = acc_r[52:16];
  assign dv      = (xv >= m0_r) ? (xv - m0_r) : (m0_r - xv);
  assign cnt_new = (status_r != STAT_MERGED) ? n_r : ((n_r == CNT_MAX) ? n_r : n1[31:0]);
  assign dtry    = {rem_r, dvd_r[140]};
  assign dge     = dtry >= {1'b0, dsor_r};
  assign strem   = {srem_r, sq_r[77:76]};
  assign strial  = {2'b00, root_r, 2'b01};
  assign sge     = strem >= strial;
  assign rnd     = ({1'b0, root_r} + 40'd1) >> 1;
  assign u_sum   = hold_r + acc_r;

  assign ram_we    = (state_r == S_FIN) && out_free && (status_r == STAT_MERGED);
  assign ram_wdata = {cnt_new, mean_r, dev_r};

  rls_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tick_nxt      = tick_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_echo_nxt  = out_echo_r;
    out_count_nxt = out_count_r;
    out_mean_nxt  = out_mean_r;
    out_std_nxt   = out_std_r;
    idx_nxt       = idx_r;
    diff_nxt      = diff_r;
    status_nxt    = status_r;
    n_nxt         = n_r;
    m0_nxt        = m0_r;
    s0_nxt        = s0_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    mean_nxt      = mean_r;
    dev_nxt       = dev_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    acc_nxt       = acc_r;
    hold_nxt      = hold_r;
    mnum_nxt      = mnum_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dsor_nxt      = dsor_r;
    dvd_nxt       = dvd_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;

    if (cfg_valid) begin
      tick_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt    = in_entry_index;
          diff_nxt   = in_end_tick - in_start_tick;
          status_nxt = (in_end_tick <= in_start_tick) ? STAT_ORDER : STAT_MERGED;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (valid_r[idx_r]) begin
          n_nxt    = ram_rdata[RAM_W-1 -: CNT_W];
          m0_nxt   = ram_rdata[2*NS_W-1 -: NS_W];
          s0_nxt   = ram_rdata[NS_W-1:0];
          mean_nxt = ram_rdata[2*NS_W-1 -: NS_W];
          dev_nxt  = ram_rdata[NS_W-1:0];
        end else begin
          n_nxt    = '0;
          m0_nxt   = '0;
          s0_nxt   = '0;
          mean_nxt = '0;
          dev_nxt  = '0;
        end
        if (status_r != STAT_MERGED) begin
          state_nxt = S_FIN;
        end else begin
          ma_nxt    = {77'b0, diff_r};
          mb_nxt    = {13'b0, tick_r};
          acc_nxt   = '0;
          op_nxt    = OP_LAT;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mb_r != '0) begin
          if (mb_r[0]) begin
            acc_nxt = acc_r + ma_r;
          end
          ma_nxt = ma_r << 1;
          mb_nxt = mb_r >> 1;
        end else begin
          // product ready: finish, or hand the next operands to the multiplier or divider
          acc_nxt = '0;
          case (op_r)
            OP_LAT: begin
              if (acc_r[87:16] > LIMIT_NS) begin
                status_nxt = STAT_RANGE;
                state_nxt  = S_FIN;
              end else if (n_r == '0) begin
                mean_nxt  = xv;
                dev_nxt   = '0;
                state_nxt = S_FIN;
              end else begin
                x_nxt  = xv;
                d_nxt  = dv;
                ma_nxt = {104'b0, m0_r};
                mb_nxt = {5'b0, n_r};
                op_nxt = OP_NM;
              end
            end
            OP_NM: begin
              mnum_nxt = {1'b0, acc_r[68:0], 1'b0} + {33'b0, x_r, 1'b0} + {38'b0, n1};
              ma_nxt   = {104'b0, s0_r};
              mb_nxt   = s0_r;
              op_nxt   = OP_SS;
            end
            OP_SS: begin
              ma_nxt = acc_r;
              mb_nxt = {4'b0, n1};
              op_nxt = OP_TS;
            end
            OP_TS: begin
              hold_nxt = acc_r;
              ma_nxt   = {104'b0, d_r};
              mb_nxt   = d_r;
              op_nxt   = OP_DD;
            end
            OP_DD: begin
              ma_nxt = u_sum;
              mb_nxt = {5'b0, n_r};
              op_nxt = OP_NU;
            end
            OP_NU: begin
              hold_nxt = acc_r << 2;
              ma_nxt   = {108'b0, n1};
              mb_nxt   = {4'b0, n1};
              op_nxt   = OP_BQ;
            end
            default: begin
              // (n+1)^2 ready: divide out the rounded mean first
              den_nxt   = acc_r[64:0];
              rem_nxt   = {33'b0, mnum_r[70:38]};
              dvd_nxt   = {mnum_r[37:0], 103'b0};
              dsor_nxt  = {32'b0, n1, 1'b0};
              q_nxt     = '0;
              cnt_nxt   = 7'd38;
              op_nxt    = OP_MEAN;
              state_nxt = S_DIV;
            end
          endcase
        end
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          rem_nxt = dge ? 66'(dtry - {1'b0, dsor_r}) : dtry[65:0];
          dvd_nxt = dvd_r << 1;
          q_nxt   = {q_r[75:0], dge};
          cnt_nxt = cnt_r - 7'd1;
        end else if (op_r == OP_MEAN) begin
          mean_nxt = q_r[37] ? NS_MAX : q_r[36:0];
          // four times the variance, floor, over (n+1)^2
          rem_nxt  = {2'b0, hold_r[140:77]};
          dvd_nxt  = {hold_r[76:0], 64'b0};
          dsor_nxt = {1'b0, den_r};
          q_nxt    = '0;
          cnt_nxt  = 7'd77;
          op_nxt   = OP_LAT;
        end else begin
          sq_nxt    = {1'b0, q_r};
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = 7'd39;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r != '0) begin
          srem_nxt = sge ? 41'(strem - strial) : strem[40:0];
          root_nxt = {root_r[37:0], sge};
          sq_nxt   = sq_r << 2;
          cnt_nxt  = cnt_r - 7'd1;
        end else begin
          // round half up: (floor(sqrt(4 var)) + 1) / 2
          dev_nxt   = (rnd[39:37] != 3'b000) ? NS_MAX : rnd[36:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_echo_nxt   = idx_r;
          out_count_nxt  = cnt_new;
          out_mean_nxt   = (cnt_new == '0) ? '0 : mean_r;
          out_std_nxt    = (cnt_new == '0) ? '0 : dev_r;
          if (status_r == STAT_MERGED) begin
            valid_nxt[idx_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LAT;
      tick_r      <= TICK_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      tick_r      <= tick_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_echo_r   <= out_echo_nxt;
    out_count_r  <= out_count_nxt;
    out_mean_r   <= out_mean_nxt;
    out_std_r    <= out_std_nxt;
    idx_r        <= idx_nxt;
    diff_r       <= diff_nxt;
    status_r     <= status_nxt;
    n_r          <= n_nxt;
    m0_r         <= m0_nxt;
    s0_r         <= s0_nxt;
    x_r          <= x_nxt;
    d_r          <= d_nxt;
    mean_r       <= mean_nxt;
    dev_r        <= dev_nxt;
    ma_r         <= ma_nxt;
    mb_r         <= mb_nxt;
    acc_r        <= acc_nxt;
    hold_r       <= hold_nxt;
    mnum_r       <= mnum_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    dsor_r       <= dsor_nxt;
    dvd_r        <= dvd_nxt;
    q_r          <= q_nxt;
    cnt_r        <= cnt_nxt;
    sq_r         <= sq_nxt;
    root_r       <= root_nxt;
    srem_r       <= srem_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_echo   = out_echo_r;
  assign out_sample_count = out_count_r;
  assign out_mean_ns      = out_mean_r;
  assign out_std_ns       = out_std_r;

endmodule

// File: dv/tb_top.sv
module tb_top;
  import rls_pkg::*;

  typedef struct {
    logic [1:0]       status;
    logic [IDX_W-1:0] entry;
    logic [CNT_W-1:0] count;
    logic [NS_W-1:0]  mean;
    logic [NS_W-1:0]  dev;
  } lat_result_t;

  class latency_board;
    logic [CNT_W-1:0]  count_q[ENTRIES];
    logic [NS_W-1:0]   mean_q[ENTRIES];
    logic [NS_W-1:0]   dev_q[ENTRIES];
    logic [TICK_W-1:0] tick;
    lat_result_t       pending[$];
    int                errors;
    int                merged, skipped;

    function new();
      foreach (count_q[i]) begin
        count_q[i] = '0;
        mean_q[i]  = '0;
        dev_q[i]   = '0;
      end
      tick = TICK_RESET;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    // exact merge of latency x into entry k
    function void merge(int k, logic [63:0] x);
      logic [255:0] n, n1, num, den, a, bq, odd, q;
      logic [63:0]  m0, s0, d;
      logic [37:0]  r, t;
      if (count_q[k] == 0) begin
        mean_q[k]  = x[NS_W-1:0];
        dev_q[k]   = '0;
        count_q[k] = 1;
        return;
      end
      n   = 256'(count_q[k]);
      n1  = n + 1;
      m0  = 64'(mean_q[k]);
      s0  = 64'(dev_q[k]);
      d   = (x >= m0) ? x - m0 : m0 - x;
      num = 2 * n * m0 + 2 * x + n1;
      den = 2 * n1;
      q   = num / den;
      if (q > 256'h3F_FFFF_FFFF) q = 256'h3F_FFFF_FFFF;
      mean_q[k] = (q > NS_MAX) ? NS_MAX : q[NS_W-1:0];
      a  = n * n1 * s0 * s0 + n * d * d;
      bq = n1 * n1;
      // round half up of sqrt(a/bq), bit by bit
      r = '0;
      for (int b = 37; b >= 0; b--) begin
        t   = r | (38'd1 << b);
        odd = 2 * t - 1;
        if (odd * odd * bq <= 4 * a) r = t;
      end
      dev_q[k] = (r > NS_MAX) ? NS_MAX : r[NS_W-1:0];
      if (count_q[k] != CNT_MAX) count_q[k] = count_q[k] + 1;
    endfunction

    function void note_request(logic [IDX_W-1:0] k, logic [63:0] st, logic [63:0] en);
      lat_result_t r;
      logic [63:0] diff, hp, x;
      r.status = STAT_MERGED;
      x = '0;
      if (en <= st) r.status = STAT_ORDER;
      else begin
        diff = en - st;
        hp   = (diff >> 32) * tick;
        if (hp >= 64'd2097152) r.status = STAT_RANGE;
        else begin
          x = (hp << 16) + (({32'd0, diff[31:0]} * tick) >> 16);
          if (x > LIMIT_NS[63:0]) r.status = STAT_RANGE;
        end
      end
      if (r.status == STAT_MERGED) begin
        merge(k, x);
        merged++;
      end else skipped++;
      r.entry = k;
      r.count = count_q[k];
      r.mean  = (count_q[k] == 0) ? '0 : mean_q[k];
      r.dev   = (count_q[k] == 0) ? '0 : dev_q[k];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(lat_result_t got);
      lat_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result for entry %0d", got.entry));
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.entry !== e.entry)
        report($sformatf("entry %0d, want %0d", got.entry, e.entry));
      if (got.count !== e.count)
        report($sformatf("entry %0d count %0d, want %0d", e.entry, got.count, e.count));
      if (got.mean !== e.mean)
        report($sformatf("entry %0d mean %0d, want %0d", e.entry, got.mean, e.mean));
      if (got.dev !== e.dev)
        report($sformatf("entry %0d std %0d, want %0d", e.entry, got.dev, e.dev));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [IDX_W-1:0]  in_entry_index;
  logic [63:0]       in_start_tick;
  logic [63:0]       in_end_tick;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [IDX_W-1:0]  out_entry_echo;
  logic [CNT_W-1:0]  out_sample_count;
  logic [NS_W-1:0]   out_mean_ns;
  logic [NS_W-1:0]   out_std_ns;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data;

  latency_board board;
  int  max_gap    = 17;
  int  max_stall  = 17;
  int  stall_left = 0;
  int  stall_seen = 0;
  int  sent       = 0;
  int  results    = 0;
  bit  holding    = 0;

  running_latency_statistics DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_entry_index   (in_entry_index),
    .in_start_tick    (in_start_tick),
    .in_end_tick      (in_end_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_echo   (out_entry_echo),
    .out_sample_count (out_sample_count),
    .out_mean_ns      (out_mean_ns),
    .out_std_ns       (out_std_ns),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      lat_result_t got;
      got.status = out_status;
      got.entry  = out_entry_echo;
      got.count  = out_sample_count;
      got.mean   = out_mean_ns;
      got.dev    = out_std_ns;
      board.check_result(got);
      results++;
    end
  end

  // draw a fresh wait after every result taken
  always @(negedge clk) begin
    if (results != stall_seen) begin
      stall_seen = results;
      stall_left = $urandom_range(0, max_stall);
    end
    if (holding) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else out_ready <= 1'b1;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (sent >= 300);
    holding = 1;
    repeat (900) @(negedge clk);
    holding = 0;
  end

  initial begin
    #40_000_000;
    $display("** running_latency_statistics: FAILED **");
    $finish;
  end

  task automatic send_request(logic [IDX_W-1:0] k, logic [63:0] st, logic [63:0] en);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_entry_index = k;
    in_start_tick  = st;
    in_end_tick    = en;
    do @(posedge clk); while (!in_ready);
    board.note_request(k, st, en);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain(int extra);
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_tick(logic [TICK_W-1:0] v);
    drain(20);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    board.tick = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_span(logic [IDX_W-1:0] k, logic [63:0] diff);
    logic [63:0] st;
    st = rand64();
    if (st + diff < st) st = st - diff;
    send_request(k, st, st + diff);
  endtask

  task automatic random_request();
    logic [IDX_W-1:0] k;
    logic [63:0]      st;
    int               pick;
    k    = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES - 1)
                                              : $urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      st = rand64();
      send_request(k, st, ($urandom_range(0, 1) == 1) ? st : st - $urandom_range(1, 1000));
    end else if (pick < 13) send_request(k, rand64(), rand64());
    else if (pick < 18) send_span(k, rand64() >> $urandom_range(0, 40));
    else if (pick < 50) send_span(k, 64'($urandom_range(1, 5000)));
    else if (pick < 80) send_span(k, 64'($urandom));
    else send_span(k, {$urandom_range(0, 31), $urandom});
  endtask

  initial begin
    logic [TICK_W-1:0] ticks[7];
    board          = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_entry_index = '0;
    in_start_tick  = '0;
    in_end_tick    = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: first sample, ordering, limits, rounding, empty entry
    send_request(8'd3, 64'd500, 64'd100);
    send_request(8'd0, 64'd0, 64'd1);
    send_request(8'd0, 64'd7, 64'd7);
    send_request(8'd0, '1, 64'd0);
    send_request(8'd255, 64'd0, '1);
    send_request(8'd1, 64'd0, 64'd100000000000);
    send_request(8'd1, 64'd5, 64'd100000000006);
    send_request(8'd1, 64'd0, 64'd2);
    send_request(8'd2, 64'd10, 64'd11);
    send_request(8'd2, 64'd10, 64'd12);
    send_request(8'd2, 64'd10, 64'd12);
    send_request(8'd2, 64'd10, 64'd13);
    send_request(8'd0, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    send_request(8'd255, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0005);
    write_tick(24'hFFFFFF);
    send_request(8'd4, 64'd0, 64'd1);
    send_request(8'd4, 64'd0, 64'd390624);
    send_request(8'd4, 64'd0, 64'd390625);
    send_request(8'd4, 64'd0, 64'h1_0000_0000);
    write_tick(24'd0);
    send_request(8'd5, 64'd0, '1);
    send_request(8'd4, 64'd3, 64'd9);
    write_tick(24'd1);
    send_request(8'd6, 64'd0, 64'd65535);
    send_request(8'd6, 64'd0, 64'd65536);
    send_request(8'd6, 64'd0, 64'd131071);

    // random phases over several tick periods, some without idling
    ticks = '{24'd65536, 24'hFFFFFF, 24'd1, 24'd0, 24'd12345, 24'd65536, 24'd300000};
    for (int ph = 0; ph < 8; ph++) begin
      write_tick((ph < 7) ? ticks[ph] : 24'($urandom_range(1, 24'hFFFFFF)));
      max_gap   = (ph % 3 == 2) ? 0 : 17;
      max_stall = (ph % 3 == 2) ? 0 : 17;
      repeat (100) random_request();
    end
    drain(500);
    $display("run: %0d requests, %0d merged, %0d skipped, %0d results checked",
             sent, board.merged, board.skipped, results);
    $display("covered tick periods 0, 1, max and others, bounds of the latency limit");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** running_latency_statistics: PASSED **");
    else
      $display("** running_latency_statistics: FAILED **");
    $finish;
  end
endmodule

// File: files.f
hdl/rls_pkg.sv
hdl/rls_ram.sv
hdl/running_latency_statistics.sv
dv/tb_top.sv
